// ===== rtl/bblur_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared widths, register indexes, queue entry types and the mean divider
// for the edge-aware 3x3 box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

    localparam int CH_W         = 8;
    localparam int SUM_W        = 12;   // 9 * 255 fits in 12 bits
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_ADDR_W   = 8;
    localparam int CFG_DATA_W   = 16;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    // power of two, so the queue pointers wrap on their own
    localparam int Q_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

    // floor(t/3) for t <= 765 and floor(t/9) for t <= 2295
    localparam logic [SUM_W-1:0] RECIP3    = SUM_W'(2731);
    localparam int               RECIP3_SH = 13;
    localparam logic [SUM_W-1:0] RECIP9    = SUM_W'(3641);
    localparam int               RECIP9_SH = 15;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // classification of one stream item, made by the front end
    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic frame_end;
    } t_cls;

    typedef struct packed {
        t_pixel px_top;
        t_pixel px_mid;
        t_pixel px_bot;
        t_cls   cls;
    } t_q_entry;

    // Divisor is 2^n2 * 3^n3: shift first, then one reciprocal multiply.
    function automatic logic [CH_W-1:0] div_mean(input logic [SUM_W-1:0] sum,
                                                 input logic [1:0] n2,
                                                 input logic [1:0] n3);
        logic [SUM_W-1:0]   t;
        logic [2*SUM_W-1:0] p;
        logic [SUM_W-1:0]   q;
        t = sum >> n2;
        q = t;
        unique case (n3)
            2'd1: begin
                p = (2*SUM_W)'(t) * (2*SUM_W)'(RECIP3);
                q = SUM_W'(p >> RECIP3_SH);
            end
            2'd2: begin
                p = (2*SUM_W)'(t) * (2*SUM_W)'(RECIP9);
                q = SUM_W'(p >> RECIP9_SH);
            end
            default: begin
                p = '0;
                q = t;
            end
        endcase
        return q[CH_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bblur_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_if
// Pixel, result and register-write channels of the box blur.
// ----------------------------------------------------------------------------
interface bblur_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bblur_pkg::CH_W-1:0] in_blue;
    logic [bblur_pkg::CH_W-1:0] in_green;
    logic [bblur_pkg::CH_W-1:0] in_red;
    logic                      drain;
    modport source(output valid, in_blue, in_green, in_red, drain, input ready);
    modport sink(input valid, in_blue, in_green, in_red, drain, output ready);
endinterface

interface bblur_res_if;
    logic                      valid;
    logic                      ready;
    logic [bblur_pkg::CH_W-1:0] out_blue;
    logic [bblur_pkg::CH_W-1:0] out_green;
    logic [bblur_pkg::CH_W-1:0] out_red;
    logic                      frame_end;
    modport source(output valid, out_blue, out_green, out_red, frame_end, input ready);
    modport sink(input valid, out_blue, out_green, out_red, frame_end, output ready);
endinterface

interface bblur_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bblur_pkg::CFG_ADDR_W-1:0] addr;
    logic [bblur_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/box_blur_3x3_edge_aware_top.sv =====
`default_nettype none
// Each stream item holds the input side through the line store read and then
// the write-back, so a new item is taken only after the write-back of the last.
// The result for stream item k leaves the output register after stream item
// k+width+1 has gone through the line stores, queue, window, sums and divider.
// Reset sets width 640 and height 480 and clears positions and window; the
// line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// Edge-aware 3x3 box mean over an RGB raster stream with register port.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bblur_pix_if.sink   i_pix,
    bblur_res_if.source o_res,
    bblur_cfg_if.sink   i_cfg
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (bblur_pkg::WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : bblur_pkg::WIDTH_RESET;
    localparam int H_RST = (bblur_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : bblur_pkg::HEIGHT_RESET;

    logic [WW-1:0]                         r_width;
    logic [HW-1:0]                         r_height;
    logic                                  cfg_write;
    logic                                  wr_width;
    logic                                  wr_height;
    logic                                  restart;
    logic [bblur_pkg::WIDTH_REG_W-1:0]     w_raw;
    logic [bblur_pkg::HEIGHT_REG_W-1:0]    h_raw;
    logic [WW-1:0]                         w_clamp;
    logic [HW-1:0]                         h_clamp;
    logic                                  q_full;
    logic                                  q_empty;
    logic                                  q_push;
    logic                                  q_pop;
    bblur_pkg::t_q_entry                   q_wdata;
    bblur_pkg::t_q_entry                   q_rdata;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;
    assign wr_width    = cfg_write && (i_cfg.addr == bblur_pkg::CFG_IMAGE_WIDTH);
    assign wr_height   = cfg_write && (i_cfg.addr == bblur_pkg::CFG_IMAGE_HEIGHT);
    assign restart     = wr_width || wr_height;

    assign w_raw = i_cfg.data[bblur_pkg::WIDTH_REG_W-1:0];
    assign h_raw = i_cfg.data[bblur_pkg::HEIGHT_REG_W-1:0];

    // zero means one, anything past the maximum means the maximum
    always_comb begin
        if (w_raw == '0) begin
            w_clamp = WW'(1);
        end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(w_raw);
        end
        if (h_raw == '0) begin
            h_clamp = HW'(1);
        end else if (32'(h_raw) > 32'(MAX_HEIGHT)) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = HW'(h_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RST);
            r_height <= HW'(H_RST);
        end else begin
            if (wr_width) begin
                r_width <= w_clamp;
            end
            if (wr_height) begin
                r_height <= h_clamp;
            end
        end
    end

    bblur_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_pix     (i_pix),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    bblur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    bblur_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (restart),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

// ===== rtl/bblur_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bblur_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_queue
// Short FIFO of classified columns between the front end and the back end.
// ----------------------------------------------------------------------------
module bblur_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire bblur_pkg::t_q_entry i_data,
    output logic                     o_full,
    input  wire logic                i_pop,
    output bblur_pkg::t_q_entry      o_data,
    output logic                     o_empty
);

    localparam int AW   = $clog2(bblur_pkg::Q_DEPTH);
    localparam int CNTW = $clog2(bblur_pkg::Q_DEPTH + 1);

    bblur_pkg::t_q_entry r_mem [bblur_pkg::Q_DEPTH];
    logic [AW-1:0]       r_wptr;
    logic [AW-1:0]       r_rptr;
    logic [CNTW-1:0]     r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNTW'(bblur_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bblur_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_front
// Accepts stream items, tracks the raster position, reads and rotates the
// two line stores and classifies each item's window for the back end.
// ----------------------------------------------------------------------------
module bblur_front #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_restart,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    i_width,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   i_height,
    bblur_pix_if.sink                              i_pix,
    input  wire logic                              i_q_full,
    output logic                                   o_q_push,
    output bblur_pkg::t_q_entry                    o_q_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);   // row runs to height+1 in the flush
    localparam int PW = 3 * bblur_pkg::CH_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_front_state;

    t_front_state     r_state, n_state;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_addr;
    bblur_pkg::t_pixel r_px;
    bblur_pkg::t_cls  r_cls;

    logic             accept;
    logic             col_zero;
    logic [WW-1:0]    w_last;
    logic [CW-1:0]    cc;
    logic [RW-1:0]    h_ext;
    logic [RW-1:0]    h_last;
    logic [RW-1:0]    row_back;
    logic [RW-1:0]    crow;
    logic [WW-1:0]    col_inc;
    bblur_pkg::t_cls  cls;
    bblur_pkg::t_pixel in_px;
    logic [PW-1:0]    upper_rdata;
    logic [PW-1:0]    mid_rdata;

    assign i_pix.ready = (r_state == S_IDLE) && !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    // centre of the window sits one row up and one column left of the item
    assign col_zero = (r_col == '0);
    assign w_last   = i_width - WW'(1);
    assign cc       = col_zero ? w_last[CW-1:0] : r_col - CW'(1);
    assign h_ext    = RW'(i_height);
    assign h_last   = h_ext - RW'(1);
    assign row_back = col_zero ? RW'(2) : RW'(1);
    assign crow     = r_row - row_back;
    assign col_inc  = WW'(r_col) + WW'(1);

    always_comb begin
        cls.emit      = (r_row >= row_back) && (crow < h_ext);
        cls.top_ok    = (crow != '0);
        cls.bot_ok    = (crow != h_last);
        cls.left_ok   = (cc != '0);
        cls.right_ok  = (cc != w_last[CW-1:0]);
        cls.frame_end = cls.emit && (crow == h_last) && (cc == w_last[CW-1:0]);
    end

    always_comb begin
        in_px.blue  = i_pix.drain ? '0 : i_pix.in_blue;
        in_px.green = i_pix.drain ? '0 : i_pix.in_green;
        in_px.red   = i_pix.drain ? '0 : i_pix.in_red;
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                    if (cls.frame_end) begin
                        n_col = '0;
                        n_row = '0;
                    end else if (col_inc == i_width) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                    end else begin
                        n_col = col_inc[CW-1:0];
                    end
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= r_col;
            r_px   <= in_px;
            r_cls  <= cls;
        end
    end

    // read both lines on accept, rotate them in the S_LOAD cycle that follows
    bblur_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr (r_addr),
        .i_wdata (mid_rdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (upper_rdata)
    );

    bblur_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr (r_addr),
        .i_wdata (r_px),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (mid_rdata)
    );

    assign o_q_push        = (r_state == S_LOAD);
    assign o_q_data.px_top = upper_rdata;
    assign o_q_data.px_mid = mid_rdata;
    assign o_q_data.px_bot = r_px;
    assign o_q_data.cls    = r_cls;

endmodule
`default_nettype wire

// ===== rtl/bblur_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_back
// Holds the 3x3 window, sums the in-image neighbors per channel and divides
// by their count; drives the result channel from an output register.
// ----------------------------------------------------------------------------
module bblur_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clear,
    input  wire bblur_pkg::t_q_entry i_q_data,
    input  wire logic                i_q_empty,
    output logic                     o_q_pop,
    bblur_res_if.source              o_res
);

    localparam int SW = bblur_pkg::SUM_W;

    bblur_pkg::t_pixel r_win [3][3];   // [row][column], column 1 is the centre
    logic              r_s1_valid;
    bblur_pkg::t_cls   r_s1_cls;
    logic              r_s2_valid;
    logic              r_s2_frame_end;
    logic [SW-1:0]     r_s2_sum_b;
    logic [SW-1:0]     r_s2_sum_g;
    logic [SW-1:0]     r_s2_sum_r;
    logic [1:0]        r_s2_n2;
    logic [1:0]        r_s2_n3;
    logic              r_out_valid;

    logic              adv;
    logic [2:0]        row_ok;
    logic [2:0]        col_ok;
    logic [SW-1:0]     sum_b;
    logic [SW-1:0]     sum_g;
    logic [SW-1:0]     sum_r;

    assign adv     = !r_out_valid || o_res.ready;
    assign o_q_pop = adv && !i_q_empty;

    // shift the window left and load the new column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (o_q_pop) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_q_data.px_top;
            r_win[1][2] <= i_q_data.px_mid;
            r_win[2][2] <= i_q_data.px_bot;
        end
    end

    assign row_ok = {r_s1_cls.bot_ok, 1'b1, r_s1_cls.top_ok};
    assign col_ok = {r_s1_cls.right_ok, 1'b1, r_s1_cls.left_ok};

    always_comb begin
        sum_b = '0;
        sum_g = '0;
        sum_r = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c]) begin
                    sum_b = sum_b + SW'(r_win[r][c].blue);
                    sum_g = sum_g + SW'(r_win[r][c].green);
                    sum_r = sum_r + SW'(r_win[r][c].red);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_q_pop && i_q_data.cls.emit;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_cls       <= i_q_data.cls;
            r_s2_frame_end <= r_s1_cls.frame_end;
            r_s2_sum_b     <= sum_b;
            r_s2_sum_g     <= sum_g;
            r_s2_sum_r     <= sum_r;
            // count = rows * columns, each 1, 2 or 3
            r_s2_n2 <= 2'(r_s1_cls.top_ok ^ r_s1_cls.bot_ok)
                     + 2'(r_s1_cls.left_ok ^ r_s1_cls.right_ok);
            r_s2_n3 <= 2'(r_s1_cls.top_ok & r_s1_cls.bot_ok)
                     + 2'(r_s1_cls.left_ok & r_s1_cls.right_ok);
            o_res.out_blue  <= bblur_pkg::div_mean(r_s2_sum_b, r_s2_n2, r_s2_n3);
            o_res.out_green <= bblur_pkg::div_mean(r_s2_sum_g, r_s2_n2, r_s2_n3);
            o_res.out_red   <= bblur_pkg::div_mean(r_s2_sum_r, r_s2_n2, r_s2_n3);
            o_res.frame_end <= r_s2_frame_end;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule
`default_nettype wire
